FILE: rtl/slj_pkg.sv
package slj_pkg;

	// field and state widths
	localparam int TIME_W   = 48;
	localparam int TS_W     = 32;
	localparam int CNT_W    = 32;
	localparam int RATE_W   = 10;
	localparam int CLIENT_W = 16;
	localparam int MINLAG_W = 16;
	localparam int LAG_W    = 50;
	localparam int SLOW_W   = 4;
	localparam int IDX_W    = 32;

	// sent frames * 1000 needs CNT_W + 10 bits
	localparam int DIVN_W   = CNT_W + 10;
	localparam int DIVC_W   = $clog2(DIVN_W + 1);

	// timing and counter constants
	localparam logic signed [TIME_W:0]  HOLD_OFF_MS    = 49'sd5000;
	localparam logic signed [TIME_W:0]  CHECK_IVL_MS   = 49'sd200;
	localparam logic signed [LAG_W:0]   DEAD_BAND_MS   = 51'sd100;
	localparam logic [SLOW_W-1:0]       SLOW_MAX       = 4'd10;
	localparam logic [SLOW_W-1:0]       SLOW_NEEDED    = 4'd3;
	localparam logic [DIVN_W-1:0]       MS_PER_S       = 42'd1000;
	localparam logic [MINLAG_W-1:0]     MIN_LAG_RESET  = 16'd1000;

	// event codes
	typedef enum logic [1:0] {
		REQ_FRAME = 2'd0,
		REQ_JUDGE = 2'd1,
		REQ_RESET = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_LAG,
		ST_CHECK,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic count_inc;
		logic clear;
		logic fill;
		logic div_start;
		logic lag_calc;
		logic check;
		logic out_load;
	} slj_cmd_t;

	// datapath -> controller
	typedef struct packed {
		req_t req;
		logic hold_ok;
		logic video;
		logic div_busy;
	} slj_stat_t;

endpackage

FILE: rtl/slj_div.sv
module slj_div
	import slj_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVN_W-1:0] dividend,
	input  logic [RATE_W-1:0] divisor,
	output logic              busy,
	output logic [DIVN_W-1:0] quotient
);

	logic [DIVC_W-1:0] cnt_q;
	logic [DIVN_W-1:0] quo_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] div_q;

	logic [RATE_W:0]   trial;
	logic              fits;
	logic [RATE_W:0]   diff;

	// one restoring step per cycle, dividend bits shift out as quotient bits shift in
	assign trial = {rem_q, quo_q[DIVN_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIVC_W'(DIVN_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIVN_W-2:0], fits};
			rem_q <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

FILE: rtl/slj_dp.sv
module slj_dp
	import slj_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  slj_cmd_t            cmd,
	output slj_stat_t           stat,
	input  logic                cfg_wr_en,
	input  logic [MINLAG_W-1:0] cfg_wr_data,
	input  logic [1:0]          req_type,
	input  logic [TIME_W-1:0]   now_ms,
	input  logic                is_video,
	input  logic [CLIENT_W-1:0] client_frames,
	input  logic [RATE_W-1:0]   frame_rate,
	input  logic [TS_W-1:0]     send_timestamp,
	input  logic                jump_ok,
	input  logic [IDX_W-1:0]    jump_target,
	output logic                jump,
	output logic [IDX_W-1:0]    jump_index
);

	// config
	logic [MINLAG_W-1:0]     min_lag_q;

	// tracking state
	logic [TIME_W-1:0]       last_jump_q;
	logic [TIME_W-1:0]       connect_q;
	logic [TS_W-1:0]         first_ts_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [LAG_W-1:0] prev_lag_q;
	logic [TIME_W-1:0]       last_check_q;
	logic [SLOW_W-1:0]       slow_q;

	// captured beat
	req_t                    req_q;
	logic [TIME_W-1:0]       now_q;
	logic                    video_q;
	logic [CLIENT_W-1:0]     client_q;
	logic [RATE_W-1:0]       rate_q;
	logic [TS_W-1:0]         ts_q;
	logic                    ok_q;
	logic [IDX_W-1:0]        target_q;

	// work registers
	logic signed [LAG_W-1:0] lag_q;
	logic                    res_q;

	logic [TIME_W-1:0]       eff_last_jump;
	logic signed [TIME_W:0]  hold_diff;
	logic [DIVN_W-1:0]       sent_ms_x;
	logic                    div_busy;
	logic [DIVN_W-1:0]       quotient;
	logic [DIVN_W-1:0]       sent_raw;
	logic [DIVN_W-1:0]       span;
	logic [DIVN_W-1:0]       sent_min;
	logic signed [LAG_W-1:0] lag_d;
	logic signed [LAG_W:0]   change;
	logic signed [TIME_W:0]  check_diff;
	logic                    check_ok;
	logic                    big_move;
	logic [SLOW_W-1:0]       slow_next;
	logic signed [LAG_W:0]   floor_sum;
	logic                    client_ok;
	logic                    jump_now;

	// hold-off test sees the last jump time as it is after the unset fill
	assign eff_last_jump = (last_jump_q == '0) ? now_q : last_jump_q;
	assign hold_diff     = $signed({1'b0, now_q}) - $signed({1'b0, eff_last_jump});

	// sent frames in ms, divided by frame rate in the divider
	assign sent_ms_x = {{(DIVN_W-CNT_W){1'b0}}, count_q} * MS_PER_S;

	slj_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sent_ms_x),
		.divisor  (rate_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// sent media time capped by timestamp span, then lag against wall time
	assign sent_raw = (rate_q == '0) ? '0 : quotient;
	assign span     = {{(DIVN_W-TS_W){1'b0}}, ts_q - first_ts_q};
	assign sent_min = (span < sent_raw) ? span : sent_raw;
	assign lag_d    = $signed({2'b00, now_q}) - $signed({2'b00, connect_q})
			- $signed({{(LAG_W-DIVN_W){1'b0}}, sent_min});

	// slowness update with dead band
	assign change     = $signed({prev_lag_q[LAG_W-1], prev_lag_q}) - $signed({lag_q[LAG_W-1], lag_q});
	assign check_diff = $signed({1'b0, now_q}) - $signed({1'b0, last_check_q});
	assign check_ok   = check_diff > CHECK_IVL_MS;
	assign big_move   = (change > DEAD_BAND_MS) || (change < -DEAD_BAND_MS);

	always_comb begin
		slow_next = slow_q;
		if (big_move && change[LAG_W] && slow_q < SLOW_MAX) begin
			slow_next = slow_q + 1'b1;
		end else if (big_move && !change[LAG_W] && slow_q != '0) begin
			slow_next = slow_q - 1'b1;
		end
	end

	// jump decision; client buffer under 1000 ms is client_frames < frame_rate
	assign floor_sum = $signed({lag_q[LAG_W-1], lag_q})
			+ $signed({{(LAG_W+1-MINLAG_W){1'b0}}, min_lag_q});
	assign client_ok = (rate_q == '0) || (client_q < {{(CLIENT_W-RATE_W){1'b0}}, rate_q});
	assign jump_now  = !floor_sum[LAG_W] && (slow_next >= SLOW_NEEDED) && client_ok && ok_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_lag_q <= MIN_LAG_RESET;
		end else if (cfg_wr_en) begin
			min_lag_q <= cfg_wr_data;
		end
	end

	// tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_jump_q  <= '0;
			connect_q    <= '0;
			first_ts_q   <= '0;
			count_q      <= '0;
			prev_lag_q   <= '0;
			last_check_q <= '0;
			slow_q       <= '0;
		end else if (cmd.clear) begin
			last_jump_q  <= '0;
			connect_q    <= '0;
			first_ts_q   <= '0;
			count_q      <= '0;
			prev_lag_q   <= '0;
			last_check_q <= '0;
			slow_q       <= '0;
		end else begin
			if (cmd.count_inc && count_q != '1) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.fill) begin
				if (last_jump_q == '0) begin
					last_jump_q <= now_q;
				end
				if (connect_q == '0) begin
					connect_q  <= now_q;
					first_ts_q <= ts_q;
				end
			end
			if (cmd.check && check_ok) begin
				last_check_q <= now_q;
				prev_lag_q   <= lag_q;
				slow_q       <= jump_now ? '0 : slow_next;
				if (jump_now) begin
					last_jump_q <= now_q;
				end
			end
		end
	end

	// beat capture and work registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= req_t'(req_type);
			now_q    <= now_ms;
			video_q  <= is_video;
			client_q <= client_frames;
			rate_q   <= frame_rate;
			ts_q     <= send_timestamp;
			ok_q     <= jump_ok;
			target_q <= jump_target;
			res_q    <= 1'b0;
		end else if (cmd.check && check_ok && jump_now) begin
			res_q <= 1'b1;
		end
		if (cmd.lag_calc) begin
			lag_q <= lag_d;
		end
		if (cmd.out_load) begin
			jump       <= res_q;
			jump_index <= res_q ? target_q : '0;
		end
	end

	assign stat.req      = req_q;
	assign stat.hold_ok  = hold_diff > HOLD_OFF_MS;
	assign stat.video    = video_q;
	assign stat.div_busy = div_busy;

endmodule

FILE: rtl/slj_ctrl.sv
module slj_ctrl
	import slj_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  slj_stat_t stat,
	output slj_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.req == REQ_JUDGE && stat.hold_ok && stat.video) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (!stat.div_busy) begin
					state_d = ST_LAG;
				end
			end
			ST_LAG:   state_d = ST_CHECK;
			ST_CHECK: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DECODE: begin
				unique case (stat.req)
					REQ_FRAME: cmd.count_inc = 1'b1;
					REQ_JUDGE: begin
						cmd.fill      = 1'b1;
						cmd.div_start = stat.hold_ok && stat.video;
					end
					REQ_RESET: cmd.clear = 1'b1;
					REQ_NONE:  cmd.clear = 1'b0;
					default:   cmd.clear = 1'b0;
				endcase
			end
			ST_DIV:   cmd.lag_calc = 1'b0;
			ST_LAG:   cmd.lag_calc = 1'b1;
			ST_CHECK: cmd.check = 1'b1;
			ST_DONE:  cmd.out_load = out_free;
			default:  cmd.out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/stream_lag_jump_detector_top.sv
// Lag jump detector for one client's live stream.
// Input channel (in_valid/in_ready): one beat per event; req_type selects
// frame sent, judge, reset of the tracking state, or no action. Output channel
// (out_valid/out_ready): exactly one result beat per input beat, in order;
// jump is 1 when the sender should skip to jump_index.
// Config: cfg_wr_en/cfg_wr_data write min_lag_ms; the user must write only while
// no beat is in flight, as the block itself does not enforce it.
// Path: frame sent, reset and no-action events, and judge events stopped by the
// 5 s hold-off or by a non-video item, go from DECODE straight to DONE. A judge
// that measures lag passes DECODE, DIV, LAG, CHECK and DONE; DIV waits for the
// bit-serial divide of sent frames * 1000 by the frame rate in the divider.
// Flow: one beat in flight; a new beat is accepted at the earliest in the cycle
// after the previous result is loaded into the output register.
// Stall: the output register holds its beat while out_ready is low; the next
// beat is still accepted and worked, and waits at the end until it frees.
// Reset: arst_n clears all tracking state and out_valid, and sets min_lag_ms
// to 1000; jump and jump_index are not reset.
module stream_lag_jump_detector_top
	import slj_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [MINLAG_W-1:0] cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          req_type,
	input  logic [TIME_W-1:0]   now_ms,
	input  logic                is_video,
	input  logic [CLIENT_W-1:0] client_frames,
	input  logic [RATE_W-1:0]   frame_rate,
	input  logic [TS_W-1:0]     send_timestamp,
	input  logic                jump_ok,
	input  logic [IDX_W-1:0]    jump_target,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                jump,
	output logic [IDX_W-1:0]    jump_index
);

	slj_cmd_t  cmd;
	slj_stat_t stat;

	slj_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	slj_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.req_type       (req_type),
		.now_ms         (now_ms),
		.is_video       (is_video),
		.client_frames  (client_frames),
		.frame_rate     (frame_rate),
		.send_timestamp (send_timestamp),
		.jump_ok        (jump_ok),
		.jump_target    (jump_target),
		.jump           (jump),
		.jump_index     (jump_index)
	);

endmodule

FILE: bench/stream_lag_jump_detector_top_tb.sv
module stream_lag_jump_detector_top_tb;
	import slj_pkg::*;

	// decision constants in ms and slowness limits, then run lengths and print cap
	localparam longint HOLD_MS      = 5000;
	localparam longint CHECK_MS     = 200;
	localparam longint BAND_MS      = 100;
	localparam longint CLIENT_MAX   = 1000;
	localparam int     SLOW_TOP     = 10;
	localparam int     SLOW_TRIGGER = 3;
	localparam int     PHASE_BEATS  = 108;
	localparam int     TAIL_CYCLES  = 64;
	localparam int     PRINT_CAP    = 40;

	typedef struct packed {
		req_t                req;
		logic [TIME_W-1:0]   now;
		logic                video;
		logic [CLIENT_W-1:0] client;
		logic [RATE_W-1:0]   rate;
		logic [TS_W-1:0]     ts;
		logic                ok;
		logic [IDX_W-1:0]    target;
	} event_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} verdict_t;

	typedef struct {
		event_t   ev;
		bit       pinned;
		verdict_t want;
	} plan_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [MINLAG_W-1:0] cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          req_type;
	logic [TIME_W-1:0]   now_ms;
	logic                is_video;
	logic [CLIENT_W-1:0] client_frames;
	logic [RATE_W-1:0]   frame_rate;
	logic [TS_W-1:0]     send_timestamp;
	logic                jump_ok;
	logic [IDX_W-1:0]    jump_target;
	logic                out_valid;
	logic                out_ready;
	logic                jump;
	logic [IDX_W-1:0]    jump_index;

	// expected verdicts, oldest first
	verdict_t  jump_expect_q[$];
	plan_row_t plan_q[$];
	int        err_cnt;
	int        verdict_n;
	int        rand_beats;

	// tracker copy kept by the bench
	logic [TIME_W-1:0]       trk_last_jump;
	logic [TIME_W-1:0]       trk_connect;
	logic [TIME_W-1:0]       trk_last_check;
	logic [TS_W-1:0]         trk_first_ts;
	logic [CNT_W-1:0]        trk_frames;
	logic signed [LAG_W-1:0] trk_prev_lag;
	logic [SLOW_W-1:0]       trk_slow;
	logic [MINLAG_W-1:0]     trk_min_lag;

	stream_lag_jump_detector_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.now_ms        (now_ms),
		.is_video      (is_video),
		.client_frames (client_frames),
		.frame_rate    (frame_rate),
		.send_timestamp(send_timestamp),
		.jump_ok       (jump_ok),
		.jump_target   (jump_target),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.jump          (jump),
		.jump_index    (jump_index)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop
	initial begin
		#6000000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic log_mismatch(input string msg);
		if (err_cnt < PRINT_CAP)
			$display("MISMATCH @%0t verdict %0d: %s", $time, verdict_n, msg);
		err_cnt++;
	endtask

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	// no gap half the time, else mostly short gaps and a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 80)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 10);
		return $urandom_range(20, 70);
	endfunction

	function automatic void clear_tracker();
		trk_last_jump  = '0;
		trk_connect    = '0;
		trk_last_check = '0;
		trk_first_ts   = '0;
		trk_frames     = '0;
		trk_prev_lag   = '0;
		trk_slow       = '0;
	endfunction

	// lag measurement and slowness vote for one judge beat
	function automatic verdict_t judge_lag(event_t e);
		verdict_t v;
		longint   now_s;
		longint   guest;
		longint   sent;
		longint   span;
		longint   lag;
		longint   change;
		v = '0;
		now_s = longint'({16'd0, e.now});
		if (trk_last_jump == '0)
			trk_last_jump = e.now;
		if (trk_connect == '0) begin
			trk_connect  = e.now;
			trk_first_ts = e.ts;
		end
		if (now_s - longint'({16'd0, trk_last_jump}) <= HOLD_MS || !e.video)
			return v;
		guest = 0;
		sent  = 0;
		if (e.rate != '0) begin
			guest = longint'({48'd0, e.client}) * 1000 / longint'({54'd0, e.rate});
			sent  = longint'({32'd0, trk_frames}) * 1000 / longint'({54'd0, e.rate});
		end
		span = longint'({32'd0, e.ts - trk_first_ts});
		if (span < sent)
			sent = span;
		lag    = (now_s - longint'({16'd0, trk_connect})) - sent;
		change = longint'(trk_prev_lag) - lag;
		if (now_s - longint'({16'd0, trk_last_check}) <= CHECK_MS)
			return v;
		// dead band around the previous lag
		if (change > BAND_MS || change < -BAND_MS) begin
			if (change < 0 && trk_slow < SLOW_TOP)
				trk_slow++;
			if (change > 0 && trk_slow > 0)
				trk_slow--;
		end
		trk_last_check = e.now;
		trk_prev_lag   = lag[LAG_W-1:0];
		if (lag >= -longint'({48'd0, trk_min_lag}) && trk_slow >= SLOW_TRIGGER &&
				guest < CLIENT_MAX && e.ok) begin
			trk_last_jump = e.now;
			trk_slow      = '0;
			v.hit = 1'b1;
			v.idx = e.target;
		end
		return v;
	endfunction

	function automatic verdict_t predict_jump(event_t e);
		verdict_t v;
		v = '0;
		case (e.req)
			REQ_FRAME: begin
				if (trk_frames != '1)
					trk_frames++;
			end
			REQ_JUDGE: v = judge_lag(e);
			REQ_RESET: clear_tracker();
			default: ;
		endcase
		return v;
	endfunction

	function automatic void add_row(req_t r, logic [TIME_W-1:0] t, logic v,
			logic [CLIENT_W-1:0] c, logic [RATE_W-1:0] fr, logic [TS_W-1:0] ts,
			logic ok, logic [IDX_W-1:0] tg, bit pinned, logic want_hit,
			logic [IDX_W-1:0] want_idx);
		plan_row_t row;
		row.ev       = '{r, t, v, c, fr, ts, ok, tg};
		row.pinned   = pinned;
		row.want.hit = want_hit;
		row.want.idx = want_idx;
		plan_q.push_back(row);
	endfunction

	// drive one beat from a falling edge, return at the falling edge after accept
	task automatic put_beat(input event_t e, input bit pinned, input verdict_t want,
			input bit calm);
		int       gap;
		verdict_t v;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type       = e.req;
		now_ms         = e.now;
		is_video       = e.video;
		client_frames  = e.client;
		frame_rate     = e.rate;
		send_timestamp = e.ts;
		jump_ok        = e.ok;
		jump_target    = e.target;
		in_valid       = 1'b1;
		v = predict_jump(e);
		jump_expect_q.push_back(pinned ? want : v);
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	function automatic event_t noise_event();
		event_t e;
		logic [1:0] code;
		code     = 2'($urandom_range(0, 3));
		e.req    = req_t'(code);
		e.now    = rand48();
		e.video  = 1'($urandom_range(0, 1));
		e.client = 16'($urandom);
		e.rate   = 10'($urandom);
		e.ts     = $urandom;
		e.ok     = 1'($urandom_range(0, 1));
		e.target = $urandom;
		return e;
	endfunction

	// one client session: mostly a reset, then frames, judges and noise, time mostly rising
	task automatic run_session(input int n_beats);
		event_t            e;
		verdict_t          none;
		logic [TIME_W-1:0] now_t;
		logic [TS_W-1:0]   ts_t;
		logic [RATE_W-1:0] fr_s;
		int                frame_pct;
		int                ts_mul;
		int                r;
		int                step;
		bit                calm;
		none  = '0;
		calm  = ($urandom_range(0, 3) == 0);
		r     = $urandom_range(0, 9);
		fr_s  = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 :
			(r == 2) ? 10'($urandom_range(1, 1023)) :
			(r < 6) ? 10'd25 : (r < 8) ? 10'd30 : 10'd60;
		r     = $urandom_range(0, 9);
		now_t = (r == 0) ? 48'($urandom_range(1, 10000)) :
			(r == 1) ? 48'hFFFF_FFFF_FFFF - 48'($urandom_range(400000, 3000000)) :
			rand48() >> $urandom_range(0, 20);
		ts_t      = $urandom;
		frame_pct = $urandom_range(10, 75);
		ts_mul    = $urandom_range(0, 3) == 0 ? 3 : 1;
		if ($urandom_range(0, 4) != 0) begin
			e = noise_event();
			e.req = REQ_RESET;
			put_beat(e, 1'b0, none, calm);
			rand_beats++;
		end
		repeat (n_beats) begin
			r = $urandom_range(0, 99);
			e = noise_event();
			if (r >= 8 && r < 8 + frame_pct) begin
				now_t = now_t + 48'($urandom_range(0, 40));
				ts_t  = ts_t + 32'($urandom_range(0, 40));
				e.req = REQ_FRAME;
				e.now = now_t;
				e.ts  = ts_t;
			end else if (r >= 8) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					step = $urandom_range(150, 450);
				else if (r < 90)
					step = $urandom_range(0, 200);
				else if (r < 97)
					step = $urandom_range(4000, 9000);
				else
					step = -1;
				if (step < 0) begin
					now_t = now_t - 48'($urandom_range(1, 3000));
				end else begin
					now_t = now_t + 48'(step);
					ts_t  = ts_t + 32'(step * ts_mul + $urandom_range(0, 60));
				end
				e.req    = REQ_JUDGE;
				e.now    = now_t;
				e.ts     = ts_t;
				e.video  = ($urandom_range(0, 99) < 92);
				e.rate   = ($urandom_range(0, 19) == 0) ? 10'($urandom) : fr_s;
				e.client = ($urandom_range(0, 9) < 7) ?
					16'($urandom_range(0, (fr_s == 0) ? 3 : fr_s)) : 16'($urandom);
				e.ok     = ($urandom_range(0, 99) < 85);
			end
			put_beat(e, 1'b0, none, calm);
			rand_beats++;
		end
	endtask

	task automatic write_min_lag(input logic [MINLAG_W-1:0] val);
		in_valid = 1'b0;
		while (jump_expect_q.size() != 0)
			@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = val;
		trk_min_lag = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// receiver: stalls of random length, with calm stretches
	initial begin : sink_pacing
		int stall_left;
		int calm_left;
		bit calm;
		stall_left = 0;
		calm_left  = 0;
		calm       = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (calm_left == 0) begin
				calm      = ($urandom_range(0, 3) == 0);
				calm_left = $urandom_range(100, 400);
			end else begin
				calm_left--;
			end
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready  = 1'b0;
				stall_left = pick_gap();
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_results
		verdict_t w;
		if (arst_n && out_valid && out_ready) begin
			if (jump_expect_q.size() == 0) begin
				log_mismatch($sformatf("unexpected beat jump=%b idx=%h", jump, jump_index));
			end else begin
				w = jump_expect_q.pop_front();
				if (jump !== w.hit)
					log_mismatch($sformatf("jump %b, expected %b", jump, w.hit));
				if (jump_index !== w.idx)
					log_mismatch($sformatf("jump_index %h, expected %h", jump_index, w.idx));
			end
			verdict_n++;
		end
	end

	initial begin : stimulus
		logic [MINLAG_W-1:0] lag_floor[6];
		err_cnt        = 0;
		verdict_n      = 0;
		rand_beats     = 0;
		trk_min_lag    = MIN_LAG_RESET;
		clear_tracker();
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		in_valid       = 1'b0;
		req_type       = REQ_FRAME;
		now_ms         = '0;
		is_video       = 1'b0;
		client_frames  = '0;
		frame_rate     = '0;
		send_timestamp = '0;
		jump_ok        = 1'b0;
		jump_target    = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed table: pinned rows carry the obvious answer
		add_row(REQ_FRAME, 48'd1, 1, 0, 30, 0, 1, 1, 1, 0, 0);
		add_row(REQ_NONE, '1, 1, '1, '1, '1, 1, '1, 1, 0, 0);
		// zero time stays unset
		add_row(REQ_JUDGE, 48'd0, 1, 0, 30, 0, 1, '1, 1, 0, 0);
		add_row(REQ_JUDGE, 48'd1000, 1, 0, 30, 100, 1, 7, 1, 0, 0);
		// past hold-off, but audio
		add_row(REQ_JUDGE, 48'd7000, 0, 0, 30, 100, 1, 7, 1, 0, 0);
		// unknown rate climbs the slowness count to a jump
		add_row(REQ_JUDGE, 48'd7000, 1, '1, 0, 100, 1, 1, 0, 0, 0);
		add_row(REQ_JUDGE, 48'd7300, 1, '1, 0, 400, 1, 2, 0, 0, 0);
		add_row(REQ_JUDGE, 48'd7400, 1, '1, 0, 500, 1, 3, 0, 0, 0);
		add_row(REQ_JUDGE, 48'd7600, 1, '1, 0, 700, 1, 32'hA5A5_5A5A, 0, 0, 0);
		add_row(REQ_JUDGE, 48'd8000, 1, 0, 30, 800, 1, 4, 1, 0, 0);
		// time running backwards
		add_row(REQ_JUDGE, 48'd500, 1, 0, 30, 800, 1, 5, 1, 0, 0);
		add_row(REQ_FRAME, 48'd8100, 0, 0, 0, 0, 0, 0, 1, 0, 0);
		add_row(REQ_FRAME, 48'd8100, 0, 0, 0, 0, 0, 0, 1, 0, 0);
		add_row(REQ_FRAME, 48'd8100, 0, 0, 0, 0, 0, 0, 1, 0, 0);
		// media timestamp below the first one wraps
		add_row(REQ_JUDGE, 48'd13000, 1, 0, 1023, 50, 1, 9, 0, 0, 0);
		add_row(REQ_JUDGE, 48'd13300, 1, 0, 1, 101, 1, 10, 0, 0, 0);
		// client buffer at the limit, then no target, then jump to index 0
		add_row(REQ_JUDGE, 48'd13600, 1, 1, 1, 200, 1, 11, 0, 0, 0);
		add_row(REQ_JUDGE, 48'd13900, 1, 0, 1, 300, 0, 12, 0, 0, 0);
		add_row(REQ_JUDGE, 48'd14200, 1, 0, 1, 400, 1, 0, 0, 0, 0);
		add_row(REQ_RESET, '1, 1, '1, '1, '1, 1, '1, 1, 0, 0);
		add_row(REQ_JUDGE, '1, 1, '1, 1023, '1, 1, '1, 1, 0, 0);
		add_row(REQ_FRAME, '1, 1, '1, 1023, '1, 1, '1, 1, 0, 0);
		add_row(REQ_JUDGE, '1, 1, 0, 1023, '1, 1, '1, 1, 0, 0);
		add_row(REQ_NONE, '0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
		foreach (plan_q[i])
			put_beat(plan_q[i].ev, plan_q[i].pinned, plan_q[i].want, 1'b0);

		// random sessions under several lag floors, reset value first
		lag_floor[0] = MIN_LAG_RESET;
		lag_floor[1] = '0;
		lag_floor[2] = '1;
		lag_floor[3] = 16'($urandom);
		lag_floor[4] = 16'd200;
		lag_floor[5] = 16'd1000;
		for (int p = 0; p < 6; p++) begin
			if (p > 0)
				write_min_lag(lag_floor[p]);
			while (rand_beats < (p + 1) * PHASE_BEATS)
				run_session($urandom_range(25, 60));
		end
		in_valid = 1'b0;

		while (jump_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
